### rtl/sha1md_pkg.sv
// Shared types, constants and round functions for the SHA-1 digest engine.
// No dependencies; used by every module under rtl/.
package sha1md_pkg;

   typedef logic [31:0] word_type;
   typedef logic [0:4][31:0] hash_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_high;
      logic [63:0] digest_middle;
      logic [31:0] digest_low;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic step;
      logic expand;
   } sched_ctrl_type;

   localparam hash_type IV = {32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe,
                              32'h1032_5476, 32'hc3d2_e1f0};

   localparam word_type K0 = 32'h5a82_7999;
   localparam word_type K1 = 32'h6ed9_eba1;
   localparam word_type K2 = 32'h8f1b_bcdc;
   localparam word_type K3 = 32'hca62_c1d6;

   localparam word_type PAD_MARKER = 32'h8000_0000;

   localparam logic [6:0] ROUND_PHASE1 = 7'd20;
   localparam logic [6:0] ROUND_PHASE2 = 7'd40;
   localparam logic [6:0] ROUND_PHASE3 = 7'd60;
   localparam logic [6:0] ROUND_LAST   = 7'd79;
   localparam logic [6:0] ROUND_EXPAND = 7'd16;

   localparam logic [3:0] POS_LEN_HI = 4'd14;
   localparam logic [3:0] POS_LEN_LO = 4'd15;

   function automatic word_type round_f(logic [6:0] rnd, word_type b, word_type c,
                                        word_type d);
      word_type f;
      if (rnd < ROUND_PHASE1) begin
         f = (b & c) | (~b & d);
      end else if (rnd < ROUND_PHASE2) begin
         f = b ^ c ^ d;
      end else if (rnd < ROUND_PHASE3) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic word_type round_k(logic [6:0] rnd);
      word_type k;
      if (rnd < ROUND_PHASE1) begin
         k = K0;
      end else if (rnd < ROUND_PHASE2) begin
         k = K1;
      end else if (rnd < ROUND_PHASE3) begin
         k = K2;
      end else begin
         k = K3;
      end
      return k;
   endfunction

endpackage

### rtl/sha1md_top.sv
// Top level of the SHA-1 digest engine: sequencer, padding, length, chaining value.
// Depends on sha1md_pkg, sha1md_sched and sha1md_round.
//
//   channel  dir  ports                          payload
//   req      in   req_valid/req_ready/req_data   word, byte_count, last
//   rsp      out  rsp_valid/rsp_ready/rsp_data   digest_high, digest_middle, digest_low
//
// Words are taken one per cycle while the sequencer is idle; the sixteenth word of a block
// starts the 80 rounds, followed by the chaining add.
// After the final word, padding words go in one per cycle and one or two more blocks run.
// The digest sits in an output register; a new message is taken while it waits, and
// only the last chaining add of the next message waits for rsp_ready.
// Reset returns the chaining value to the initial vector; the schedule is not cleared.
module sha1_message_digest_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha1md_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha1md_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PAD   = 4'b0010,
      ST_ROUND = 4'b0100,
      ST_ADD   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0]  pos_ff, pos_in;
   logic [6:0]  round_ff, round_in;
   logic [60:0] bytes_ff, bytes_in;
   sha1md_pkg::hash_type cv_ff, cv_in;
   logic mark_ff, mark_in;
   logic hi_ff, hi_in;
   logic lo_ff, lo_in;
   logic pad_ff, pad_in;
   logic rsp_valid_ff, rsp_valid_in;
   sha1md_pkg::rsp_type rsp_data_ff, rsp_data_in;

   sha1md_pkg::sched_ctrl_type sched_ctrl;
   sha1md_pkg::word_type push_word;
   sha1md_pkg::word_type w;
   sha1md_pkg::hash_type r_q;
   sha1md_pkg::hash_type sum;
   logic       round_load;
   logic       req_fire;
   logic [2:0] count_eff;
   logic [63:0] bit_len;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign bit_len   = {bytes_ff, 3'b000};

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         sum[i] = cv_ff[i] + r_q[i];
      end
   end

   always_comb begin
      if (!req_data.last || req_data.byte_count > 3'd4) begin
         count_eff = 3'd4;
      end else begin
         count_eff = req_data.byte_count;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      round_in     = round_ff;
      bytes_in     = bytes_ff;
      cv_in        = cv_ff;
      mark_in      = mark_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      pad_in       = pad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      push_word    = req_data.word;
      sched_ctrl   = '0;
      round_load   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               bytes_in = bytes_ff + 61'(count_eff);
               if (req_data.last) begin
                  pad_in = 1'b1;
                  case (req_data.byte_count)
                     3'd0: push_word = sha1md_pkg::PAD_MARKER;
                     3'd1: push_word = {req_data.word[31:24], 24'h80_0000};
                     3'd2: push_word = {req_data.word[31:16], 16'h8000};
                     3'd3: push_word = {req_data.word[31:8], 8'h80};
                     default: begin
                        push_word = req_data.word;
                        mark_in   = 1'b1;
                     end
                  endcase
               end
               sched_ctrl.push = 1'b1;
               pos_in = pos_ff + 4'd1;
               if (pos_ff == sha1md_pkg::POS_LEN_LO) begin
                  state_in   = ST_ROUND;
                  round_load = 1'b1;
               end else if (req_data.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (mark_ff) begin
               push_word = sha1md_pkg::PAD_MARKER;
               mark_in   = 1'b0;
            end else if (hi_ff) begin
               push_word = bit_len[31:0];
               lo_in     = 1'b1;
            end else if (pos_ff == sha1md_pkg::POS_LEN_HI) begin
               push_word = bit_len[63:32];
               hi_in     = 1'b1;
            end else begin
               push_word = '0;
            end
            sched_ctrl.push = 1'b1;
            pos_in = pos_ff + 4'd1;
            if (pos_ff == sha1md_pkg::POS_LEN_LO) begin
               state_in   = ST_ROUND;
               round_load = 1'b1;
            end
         end
         ST_ROUND: begin
            sched_ctrl.step   = 1'b1;
            sched_ctrl.expand = (round_ff >= sha1md_pkg::ROUND_EXPAND);
            if (round_ff == sha1md_pkg::ROUND_LAST) begin
               round_in = '0;
               state_in = ST_ADD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_ADD: begin
            if (!lo_ff) begin
               cv_in    = sum;
               state_in = pad_ff ? ST_PAD : ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.digest_high   = {sum[0], sum[1]};
               rsp_data_in.digest_middle = {sum[2], sum[3]};
               rsp_data_in.digest_low    = sum[4];
               cv_in    = sha1md_pkg::IV;
               bytes_in = '0;
               pos_in   = '0;
               mark_in  = 1'b0;
               hi_in    = 1'b0;
               lo_in    = 1'b0;
               pad_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         round_ff     <= '0;
         bytes_ff     <= '0;
         cv_ff        <= sha1md_pkg::IV;
         mark_ff      <= 1'b0;
         hi_ff        <= 1'b0;
         lo_ff        <= 1'b0;
         pad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         bytes_ff     <= bytes_in;
         cv_ff        <= cv_in;
         mark_ff      <= mark_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   sha1md_sched u_sched (
      .clock     (clock),
      .ctrl      (sched_ctrl),
      .push_word (push_word),
      .w_out     (w)
   );

   sha1md_round u_round (
      .clock      (clock),
      .load       (round_load),
      .load_value (cv_ff),
      .step       (sched_ctrl.step),
      .rnd        (round_ff),
      .w          (w),
      .regs       (r_q)
   );

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_round_to_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && (round_ff == sha1md_pkg::ROUND_LAST) |=> (state_ff == ST_ADD))
      else $error("compression did not end after the last round");

   a_block_aligned: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_ROUND) |-> (pos_ff == 4'd0) && (round_ff == 7'd0))
      else $error("compression started on a partial block");

   a_len_order: assert property (@(posedge clock) disable iff (reset)
      lo_ff |-> hi_ff && pad_ff && !mark_ff)
      else $error("length words out of order");

   a_pad_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> pad_ff)
      else $error("padding without a final word");
`endif

endmodule

### rtl/sha1md_sched.sv
// 16-word message schedule shift ring with in-place W expansion.
// Depends on sha1md_pkg.
module sha1md_sched (
   input  logic                       clock,
   input  sha1md_pkg::sched_ctrl_type ctrl,
   input  sha1md_pkg::word_type       push_word,
   output sha1md_pkg::word_type       w_out
);

   sha1md_pkg::word_type ring_ff [16];
   sha1md_pkg::word_type expanded;
   sha1md_pkg::word_type step_word;

   always_comb begin
      expanded  = ring_ff[13] ^ ring_ff[8] ^ ring_ff[2] ^ ring_ff[0];
      step_word = ctrl.expand ? {expanded[30:0], expanded[31]} : ring_ff[0];
   end

   assign w_out = step_word;

   always_ff @(posedge clock) begin
      if (ctrl.push || ctrl.step) begin
         for (int i = 0; i < 15; i++) begin
            ring_ff[i] <= ring_ff[i+1];
         end
         ring_ff[15] <= ctrl.push ? push_word : step_word;
      end
   end

endmodule

### rtl/sha1md_round.sv
// SHA-1 round unit: the five working registers and one round per step.
// Depends on sha1md_pkg.
module sha1md_round (
   input  logic                 clock,
   input  logic                 load,
   input  sha1md_pkg::hash_type load_value,
   input  logic                 step,
   input  logic [6:0]           rnd,
   input  sha1md_pkg::word_type w,
   output sha1md_pkg::hash_type regs
);

   sha1md_pkg::hash_type r_ff;
   sha1md_pkg::hash_type r_in;
   sha1md_pkg::word_type t;

   always_comb begin
      t = {r_ff[0][26:0], r_ff[0][31:27]}
          + sha1md_pkg::round_f(rnd, r_ff[1], r_ff[2], r_ff[3])
          + r_ff[4] + sha1md_pkg::round_k(rnd) + w;
      r_in[0] = t;
      r_in[1] = r_ff[0];
      r_in[2] = {r_ff[1][1:0], r_ff[1][31:2]};
      r_in[3] = r_ff[2];
      r_in[4] = r_ff[3];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         r_ff <= load_value;
      end else if (step) begin
         r_ff <= r_in;
      end
   end

   assign regs = r_ff;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the SHA-1 digest engine: random and directed messages.
// The bench has its own SHA-1 model with padding, and it checks every digest.
// Depends on sha1md_pkg and sha1_message_digest_top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_REQUESTS = 750;
   localparam int HOLD_OFF_CYCLES = 2500;
   localparam logic [159:0] START_CHAIN = 160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
   localparam logic [31:0] K_ROUND0 = 32'h5a827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
   localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;
   localparam logic [31:0] END_MARKER = 32'h80000000;
   localparam logic [2:0] FULL_WORD = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   sha1md_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sha1md_pkg::rsp_type rsp_data;

   sha1md_pkg::req_type message_words[$];
   sha1md_pkg::rsp_type expected_digests[$];

   logic [31:0] chain [5];
   logic [31:0] sched [16];
   logic [3:0] slot_pos;
   logic [60:0] msg_bytes;

   int gap_left = 0;
   int stall_left = 0;
   bit hold_done = 1'b0;
   bit quiet_tail = 1'b0;
   int requests_taken = 0;
   int messages_taken = 0;
   int digests_checked = 0;
   int mismatches = 0;
   int cycle_count = 0;

   sha1_message_digest_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic restart_chain();
      for (int i = 0; i < 5; i++) chain[i] = START_CHAIN[159 - 32 * i -: 32];
      slot_pos = '0;
      msg_bytes = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t;
      w = sched;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
         if (r >= 16)
            w[r % 16] = rotate_left(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^
                                    w[(r + 2) % 16] ^ w[r % 16], 1);
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND3;
         end
         t = rotate_left(a, 5) + f + e + k + w[r % 16];
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endtask

   task automatic append_word(input logic [31:0] w);
      sched[slot_pos] = w;
      slot_pos = slot_pos + 4'd1;
      if (slot_pos == 4'd0) compress_block();
   endtask

   // Absorb one accepted request; on the final word pad, finish and queue the digest.
   task automatic hash_request(input sha1md_pkg::req_type rq);
      logic [2:0] n;
      logic [31:0] keep;
      logic [63:0] bits;
      sha1md_pkg::rsp_type d;
      n = (rq.byte_count > FULL_WORD || !rq.last) ? FULL_WORD : rq.byte_count;
      msg_bytes = msg_bytes + 61'(n);
      if (!rq.last) begin
         append_word(rq.word);
      end else begin
         if (n == FULL_WORD) begin
            append_word(rq.word);
            append_word(END_MARKER);
         end else begin
            keep = (n == 3'd0) ? 32'h0 : ~(32'hffffffff >> (8 * n));
            append_word((rq.word & keep) | (32'h80 << (24 - 8 * n)));
         end
         while (slot_pos != 4'd14) append_word(32'h0);
         bits = {msg_bytes, 3'b000};
         append_word(bits[63:32]);
         append_word(bits[31:0]);
         d.digest_high = {chain[0], chain[1]};
         d.digest_middle = {chain[2], chain[3]};
         d.digest_low = chain[4];
         expected_digests.push_back(d);
         restart_chain();
      end
   endtask

   task automatic push_request(input logic [31:0] w, input logic [2:0] n, input logic fin);
      sha1md_pkg::req_type rq;
      rq.word = w;
      rq.byte_count = n;
      rq.last = fin;
      message_words.push_back(rq);
   endtask

   // Well-formed body words, with an occasional odd byte count before the end.
   task automatic add_message(input int words, input logic [2:0] tail_count);
      for (int i = 1; i < words; i++)
         push_request($urandom, ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                             : FULL_WORD, 1'b0);
      push_request($urandom, tail_count, 1'b1);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            hash_request(req_data);
            requests_taken++;
            if (req_data.last) messages_taken++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (message_words.size() != 0) begin
               req_data <= message_words.pop_front();
               req_valid <= 1'b1;
               if (!quiet_tail && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
         quiet_tail <= (message_words.size() < 60);
      end
   end

   // digest receiver with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && digests_checked == 4) begin
         hold_done <= 1'b1;
         stall_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 10) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // digest checker
   always @(posedge clock) begin
      sha1md_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digests.size() == 0) begin
            $display("%0t: digest expected none actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = expected_digests.pop_front();
            if (rsp_data.digest_high !== want.digest_high) begin
               $display("%0t: digest_high expected %h actual %h", $time, want.digest_high,
                        rsp_data.digest_high);
               mismatches++;
            end
            if (rsp_data.digest_middle !== want.digest_middle) begin
               $display("%0t: digest_middle expected %h actual %h", $time,
                        want.digest_middle, rsp_data.digest_middle);
               mismatches++;
            end
            if (rsp_data.digest_low !== want.digest_low) begin
               $display("%0t: digest_low expected %h actual %h", $time, want.digest_low,
                        rsp_data.digest_low);
               mismatches++;
            end
            digests_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d digests still pending", $time, expected_digests.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      restart_chain();
      // empty message, the ignored word all ones
      push_request(32'hffffffff, 3'd0, 1'b1);
      push_request(32'h616263ff, 3'd3, 1'b1);
      push_request(32'h00000000, 3'd4, 1'b1);
      push_request(32'hffffffff, 3'd1, 1'b1);
      push_request(32'hffffffff, 3'd2, 1'b1);
      push_request(32'h12345678, 3'd5, 1'b1);
      push_request(32'h9abcdef0, 3'd6, 1'b1);
      push_request(32'hffffffff, 3'd7, 1'b1);
      // short word before the end is still taken whole
      push_request(32'hdeadbeef, 3'd0, 1'b0);
      push_request(32'hcafef00d, 3'd2, 1'b1);
      // fourteen full words: the marker and length need a second block
      for (int i = 0; i < 13; i++) push_request((i % 2) ? 32'hffffffff : 32'h0, 3'd4, 1'b0);
      push_request(32'ha5a5a5a5, 3'd4, 1'b1);
      while (message_words.size() < RANDOM_REQUESTS + 24) begin
         if ($urandom_range(0, 9) == 0) add_message($urandom_range(17, 48),
                                                    3'($urandom_range(0, 7)));
         else add_message($urandom_range(1, 16), 3'($urandom_range(0, 7)));
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (message_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Hashed %0d messages from %0d requests, including empty, ragged and",
               messages_taken, requests_taken);
      $display("two-block padding cases; %0d digests compared, %0d mismatches",
               digests_checked, mismatches);
      if (mismatches == 0 && expected_digests.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
